@@ hdl/fpl_pkg.sv @@
// Types, constants and the microcode ROM for the four-pole ladder filter.
// No dependencies; every other file refers to it by scoped names.
package fpl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STATE_W    = 48;
    localparam int POLES      = 4;
    localparam int POLE_W     = $clog2(POLES);
    localparam int PC_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // Shared multiplier: 48-bit operand split into two 24-bit halves
    localparam int HALF_W     = 24;
    localparam int MOP_W      = HALF_W + 1;
    localparam int COEF_W     = 20;
    localparam int PROD_W     = MOP_W + COEF_W;
    localparam int MAC_W      = STATE_W + COEF_W;
    localparam int ACC_W      = STATE_W + 2;
    localparam int COEF_FRAC  = 16;

    localparam logic signed [COEF_W-1:0] TAP_COEF = 20'sd19661;   // 0.3 in Q3.16

    localparam logic signed [STATE_W-1:0] STATE_MAX = 48'sh7FFFFFFFFFFF;
    localparam logic signed [STATE_W-1:0] STATE_MIN = -STATE_MAX - 48'sd1;
    localparam logic signed [MAC_W-1:0]   SAT_HI    = 68'sh7FFFFFFFFFFF;
    localparam logic signed [MAC_W-1:0]   SAT_LO    = -SAT_HI - 68'sd1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 3'd4;

    // Output modes; the unused code acts as lowpass
    localparam logic [1:0] MODE_LOWPASS  = 2'd0;
    localparam logic [1:0] MODE_BANDPASS = 2'd1;
    localparam logic [1:0] MODE_HIGHPASS = 2'd2;

    // Microprogram addresses
    localparam logic [PC_W-1:0] PC_START = 4'd0;
    localparam logic [PC_W-1:0] PC_POLE  = 4'd6;
    localparam logic [PC_W-1:0] PC_OUT   = 4'd12;

    typedef struct packed {
        logic                        enable;
        logic [1:0]                  mode;
        logic [18:0]                 feedback_gain;
        logic [15:0]                 input_gain;
        logic signed [17:0]          pole_decay;
    } cfg_t;

    typedef enum logic [1:0] {MUL_NONE, MUL_LO, MUL_HI} mul_op_t;
    typedef enum logic [1:0] {ASEL_SO_LAST, ASEL_ACC, ASEL_SP_K, ASEL_SO_K} a_sel_t;
    typedef enum logic [1:0] {CSEL_FB, CSEL_IG, CSEL_TAP, CSEL_DECAY} c_sel_t;
    typedef enum logic [2:0] {ACC_NONE, ACC_LOAD_X, ACC_LOAD_S, ACC_ADD_T, ACC_SUB_T} acc_op_t;
    typedef enum logic [1:0] {WR_NONE, WR_U, WR_POLE, WR_OUT} wr_op_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOOP, SEQ_END} seq_op_t;

    typedef struct packed {
        mul_op_t         mul_op;
        a_sel_t          a_sel;
        c_sel_t          c_sel;
        acc_op_t         acc_op;
        wr_op_t          wr_op;
        seq_op_t         seq_op;
        logic            k_clr;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        ucode_t            uc;
        logic [POLE_W-1:0] pole;
        logic              load_x;
    } dp_ctrl_t;

    localparam ucode_t UC_NOP = '{MUL_NONE, ASEL_SO_LAST, CSEL_FB, ACC_NONE,
                                  WR_NONE, SEQ_NEXT, 1'b0, PC_START};

    function automatic ucode_t uc_word(mul_op_t m, a_sel_t a, c_sel_t c, acc_op_t acc,
                                       wr_op_t wr, seq_op_t sq, logic kc,
                                       logic [PC_W-1:0] tgt);
        ucode_t w;
        w.mul_op = m;
        w.a_sel  = a;
        w.c_sel  = c;
        w.acc_op = acc;
        w.wr_op  = wr;
        w.seq_op = sq;
        w.k_clr  = kc;
        w.target = tgt;
        return w;
    endfunction

    // Microprogram: feedback, input gain, one pass of steps 6..11 per pole, then the output step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            4'd0:  w = uc_word(MUL_LO, ASEL_SO_LAST, CSEL_FB, ACC_LOAD_X,
                               WR_NONE, SEQ_NEXT, 1'b1, PC_START);
            4'd1:  w = uc_word(MUL_HI, ASEL_SO_LAST, CSEL_FB, ACC_NONE,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd2:  w = uc_word(MUL_NONE, ASEL_ACC, CSEL_IG, ACC_SUB_T,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd3:  w = uc_word(MUL_LO, ASEL_ACC, CSEL_IG, ACC_NONE,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd4:  w = uc_word(MUL_HI, ASEL_ACC, CSEL_IG, ACC_NONE,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd5:  w = uc_word(MUL_NONE, ASEL_ACC, CSEL_IG, ACC_NONE,
                               WR_U, SEQ_NEXT, 1'b0, PC_START);
            4'd6:  w = uc_word(MUL_LO, ASEL_SP_K, CSEL_TAP, ACC_LOAD_S,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd7:  w = uc_word(MUL_HI, ASEL_SP_K, CSEL_TAP, ACC_NONE,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd8:  w = uc_word(MUL_LO, ASEL_SO_K, CSEL_DECAY, ACC_ADD_T,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd9:  w = uc_word(MUL_HI, ASEL_SO_K, CSEL_DECAY, ACC_NONE,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd10: w = uc_word(MUL_NONE, ASEL_SO_K, CSEL_DECAY, ACC_ADD_T,
                               WR_NONE, SEQ_NEXT, 1'b0, PC_START);
            4'd11: w = uc_word(MUL_NONE, ASEL_SO_K, CSEL_DECAY, ACC_NONE,
                               WR_POLE, SEQ_LOOP, 1'b0, PC_POLE);
            4'd12: w = uc_word(MUL_NONE, ASEL_SO_LAST, CSEL_FB, ACC_NONE,
                               WR_OUT, SEQ_END, 1'b0, PC_START);
            default: w = uc_word(MUL_NONE, ASEL_SO_LAST, CSEL_FB, ACC_NONE,
                                 WR_NONE, SEQ_END, 1'b0, PC_START);
        endcase
        return w;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat48(input logic signed [MAC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > SAT_HI)
            r = STATE_MAX;
        else if (v < SAT_LO)
            r = STATE_MIN;
        else
            r = v[STATE_W-1:0];
        return r;
    endfunction

endpackage

@@ hdl/fpl_if.sv @@
// Valid/ready channel interfaces for input samples and filtered results.
// Depends on fpl_pkg for the sample width.
interface fpl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fpl_pkg::SAMPLE_W-1:0]   sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface fpl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fpl_pkg::SAMPLE_W-1:0]   sample_out;
    logic                                  clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

@@ hdl/fpl_seq.sv @@
// Microcode sequencer: step counter, pole counter and ROM lookup.
// Depends on fpl_pkg for the control word and the ROM.
module fpl_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                enable,
    input  logic                out_free,
    output logic                ready,
    output fpl_pkg::dp_ctrl_t   ctrl
);

    logic                          run_reg, run_next;
    logic [fpl_pkg::PC_W-1:0]      pc_reg, pc_next;
    logic [fpl_pkg::POLE_W-1:0]    k_reg, k_next;
    fpl_pkg::ucode_t               word;
    logic                          stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pc_reg  <= fpl_pkg::PC_START;
            k_reg   <= '0;
        end
        else
        begin
            run_reg <= run_next;
            pc_reg  <= pc_next;
            k_reg   <= k_next;
        end
    end

    always_comb
    begin
        word  = fpl_pkg::ucode_rom(pc_reg);
        // the result step waits for the output register
        stall = run_reg && (word.seq_op == fpl_pkg::SEQ_END) && !out_free;

        ctrl.uc     = run_reg ? word : fpl_pkg::UC_NOP;
        if (stall)
            ctrl.uc.wr_op = fpl_pkg::WR_NONE;
        ctrl.pole   = k_reg;
        ctrl.load_x = start;
        ready       = !run_reg;

        run_next = run_reg;
        pc_next  = pc_reg;
        k_next   = k_reg;

        if (!run_reg)
        begin
            if (start)
            begin
                run_next = 1'b1;
                pc_next  = enable ? fpl_pkg::PC_START : fpl_pkg::PC_OUT;
            end
        end
        else
        begin
            if (word.k_clr)
                k_next = '0;
            else if (word.wr_op == fpl_pkg::WR_POLE)
                k_next = k_reg + 1'b1;

            case (word.seq_op)
                fpl_pkg::SEQ_NEXT: pc_next = pc_reg + 1'b1;
                fpl_pkg::SEQ_LOOP:
                begin
                    if (k_reg != fpl_pkg::POLE_W'(fpl_pkg::POLES - 1))
                        pc_next = word.target;
                    else
                        pc_next = pc_reg + 1'b1;
                end
                fpl_pkg::SEQ_END:
                begin
                    if (!stall)
                    begin
                        run_next = 1'b0;
                        pc_next  = fpl_pkg::PC_START;
                    end
                end
                default: pc_next = fpl_pkg::PC_START;
            endcase
        end
    end

endmodule

@@ hdl/fpl_dp.sv @@
// Datapath: shared 25x20 multiply-accumulate, sum register, pole state and
// result register. Driven by the control word from fpl_seq; uses fpl_pkg.
module fpl_dp
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fpl_pkg::dp_ctrl_t                    ctrl,
    input  fpl_pkg::cfg_t                        cfg,
    input  logic signed [fpl_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                 out_ready,
    output logic                                 out_free,
    output logic                                 out_valid,
    output logic signed [fpl_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                                 clipped
);

    localparam int SW = fpl_pkg::STATE_W;
    localparam int X_W = fpl_pkg::SAMPLE_W + FRAC_BITS;
    localparam logic signed [SW:0] ROUND = (SW+1)'(1) <<< (FRAC_BITS - 1);

    logic signed [fpl_pkg::SAMPLE_W-1:0]  x_reg;
    logic signed [fpl_pkg::ACC_W-1:0]     acc_reg;
    logic signed [fpl_pkg::MAC_W-1:0]     mq_reg;
    logic signed [SW-1:0]                 u_reg;
    logic signed [SW-1:0]                 s_reg;
    logic signed [SW-1:0]                 so_reg [fpl_pkg::POLES];
    logic signed [SW-1:0]                 sp_reg [fpl_pkg::POLES];
    logic                                 out_valid_reg;
    logic signed [fpl_pkg::SAMPLE_W-1:0]  sample_out_reg;
    logic                                 clipped_reg;

    logic signed [SW-1:0]                 a_op;
    logic signed [fpl_pkg::MOP_W-1:0]     a_half;
    logic signed [fpl_pkg::COEF_W-1:0]    c_op;
    logic signed [fpl_pkg::PROD_W-1:0]    prod;
    logic signed [SW-1:0]                 term;
    logic signed [SW-1:0]                 acc_sat;
    logic signed [X_W-1:0]                x_scaled;

    logic signed [SW:0]                   band_diff;
    logic signed [SW+2:0]                 band_x3;
    logic signed [SW-1:0]                 v_sel;
    logic signed [SW:0]                   v_rnd;
    logic signed [SW:0]                   r_val;
    logic                                 clip_hi, clip_lo;
    logic signed [fpl_pkg::SAMPLE_W-1:0]  filt_out;

    // Multiplier operands
    always_comb
    begin
        acc_sat = fpl_pkg::sat48(fpl_pkg::MAC_W'(acc_reg));
        case (ctrl.uc.a_sel)
            fpl_pkg::ASEL_SO_LAST: a_op = so_reg[fpl_pkg::POLES-1];
            fpl_pkg::ASEL_ACC:     a_op = acc_sat;
            fpl_pkg::ASEL_SP_K:    a_op = sp_reg[ctrl.pole];
            fpl_pkg::ASEL_SO_K:    a_op = so_reg[ctrl.pole];
            default:               a_op = so_reg[fpl_pkg::POLES-1];
        endcase

        if (ctrl.uc.mul_op == fpl_pkg::MUL_HI)
            a_half = fpl_pkg::MOP_W'($signed(a_op[SW-1:fpl_pkg::HALF_W]));
        else
            a_half = $signed({1'b0, a_op[fpl_pkg::HALF_W-1:0]});

        case (ctrl.uc.c_sel)
            fpl_pkg::CSEL_FB:    c_op = $signed({1'b0, cfg.feedback_gain});
            fpl_pkg::CSEL_IG:    c_op = $signed({4'b0, cfg.input_gain});
            fpl_pkg::CSEL_TAP:   c_op = fpl_pkg::TAP_COEF;
            fpl_pkg::CSEL_DECAY: c_op = fpl_pkg::COEF_W'(cfg.pole_decay);
            default:             c_op = fpl_pkg::TAP_COEF;
        endcase

        prod     = a_half * c_op;
        term     = fpl_pkg::sat48(mq_reg >>> fpl_pkg::COEF_FRAC);
        x_scaled = X_W'(x_reg) <<< FRAC_BITS;
    end

    // Output selection, round half up, saturate to the sample range
    always_comb
    begin
        band_diff = (SW+1)'(so_reg[2]) - (SW+1)'(so_reg[fpl_pkg::POLES-1]);
        band_x3   = (SW+3)'(band_diff) + ((SW+3)'(band_diff) <<< 1);
        case (cfg.mode)
            fpl_pkg::MODE_BANDPASS:
                v_sel = fpl_pkg::sat48(fpl_pkg::MAC_W'(band_x3));
            fpl_pkg::MODE_HIGHPASS:
                v_sel = fpl_pkg::sat48(fpl_pkg::MAC_W'(u_reg)
                                       - fpl_pkg::MAC_W'(so_reg[fpl_pkg::POLES-1]));
            default:
                v_sel = so_reg[fpl_pkg::POLES-1];
        endcase
        v_rnd   = (SW+1)'(v_sel) + ROUND;
        r_val   = v_rnd >>> FRAC_BITS;
        clip_hi = r_val > (SW+1)'(32767);
        clip_lo = r_val < -(SW+1)'(32768);
        if (clip_hi)
            filt_out = 16'sh7FFF;
        else if (clip_lo)
            filt_out = 16'sh8000;
        else
            filt_out = r_val[fpl_pkg::SAMPLE_W-1:0];
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_x)
            x_reg <= sample_in;

        case (ctrl.uc.mul_op)
            fpl_pkg::MUL_LO: mq_reg <= fpl_pkg::MAC_W'(prod);
            fpl_pkg::MUL_HI: mq_reg <= mq_reg + (fpl_pkg::MAC_W'(prod) <<< fpl_pkg::HALF_W);
            default:         mq_reg <= mq_reg;
        endcase

        case (ctrl.uc.acc_op)
            fpl_pkg::ACC_LOAD_X: acc_reg <= fpl_pkg::ACC_W'(x_scaled);
            fpl_pkg::ACC_LOAD_S: acc_reg <= fpl_pkg::ACC_W'(s_reg);
            fpl_pkg::ACC_ADD_T:  acc_reg <= acc_reg + fpl_pkg::ACC_W'(term);
            fpl_pkg::ACC_SUB_T:  acc_reg <= acc_reg - fpl_pkg::ACC_W'(term);
            default:             acc_reg <= acc_reg;
        endcase

        if (ctrl.uc.wr_op == fpl_pkg::WR_U)
        begin
            u_reg <= term;
            s_reg <= term;
        end
        else if (ctrl.uc.wr_op == fpl_pkg::WR_POLE)
            s_reg <= acc_sat;

        if (ctrl.uc.wr_op == fpl_pkg::WR_OUT)
        begin
            sample_out_reg <= cfg.enable ? filt_out : x_reg;
            clipped_reg    <= cfg.enable && (clip_hi || clip_lo);
        end
    end

    // Pole state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpl_pkg::POLES; i++)
            begin
                so_reg[i] <= '0;
                sp_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.uc.wr_op == fpl_pkg::WR_POLE)
            begin
                so_reg[ctrl.pole] <= acc_sat;
                sp_reg[ctrl.pole] <= s_reg;
            end
            if (ctrl.uc.wr_op == fpl_pkg::WR_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

endmodule

@@ hdl/four_pole_ladder_filter.sv @@
// Four-pole ladder filter: a microcode sequencer runs each accepted item through the
// program and takes no new item until that item's result is written. A bypassed item
// (enable low) runs only the output step. Ten coefficient products per item, each two
// passes of the one 25x20 multiplier, plus sum and write steps, make up the program.
// Reset clears the configuration (pole_decay to 1.0), the pole state and the
// result valid flag; no clearing pass.
module four_pole_ladder_filter
#(
    parameter int STATE_FRACTION_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    fpl_in_if.sink                               samples,
    fpl_out_if.source                            results,
    input  logic                                 cfg_we,
    input  logic [fpl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fpl_pkg::CFG_DATA_W-1:0]       cfg_data
);

    fpl_pkg::cfg_t      cfg_reg;
    fpl_pkg::dp_ctrl_t  ctrl;
    logic               start;
    logic               seq_ready;
    logic               out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= 1'b0;
            cfg_reg.mode          <= fpl_pkg::MODE_LOWPASS;
            cfg_reg.feedback_gain <= '0;
            cfg_reg.input_gain    <= '0;
            cfg_reg.pole_decay    <= 18'sh10000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fpl_pkg::REG_ENABLE:   cfg_reg.enable        <= cfg_data[0];
                fpl_pkg::REG_MODE:     cfg_reg.mode          <= cfg_data[1:0];
                fpl_pkg::REG_FEEDBACK: cfg_reg.feedback_gain <= cfg_data[18:0];
                fpl_pkg::REG_IN_GAIN:  cfg_reg.input_gain    <= cfg_data[15:0];
                fpl_pkg::REG_DECAY:    cfg_reg.pole_decay    <= $signed(cfg_data[17:0]);
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign samples.ready = seq_ready;
    assign start         = samples.valid && seq_ready;

    fpl_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .enable   (cfg_reg.enable),
        .out_free (out_free),
        .ready    (seq_ready),
        .ctrl     (ctrl)
    );

    fpl_dp #(
        .FRAC_BITS (STATE_FRACTION_BITS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg        (cfg_reg),
        .sample_in  (samples.sample_in),
        .out_ready  (results.ready),
        .out_free   (out_free),
        .out_valid  (results.valid),
        .sample_out (results.sample_out),
        .clipped    (results.clipped)
    );

    // Not ready in the cycle after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("input accepted on consecutive cycles");

    // Pole counter has wrapped back to zero whenever the sequencer is idle
    a_pole_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        samples.ready |-> (ctrl.pole == '0))
        else $error("pole counter not zero while idle");

    // A result only appears after the output step of the program
    a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(ctrl.uc.wr_op == fpl_pkg::WR_OUT))
        else $error("result valid without an output step");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for four_pole_ladder_filter: random sample streams under many settings,
// with a bit-true ladder filter model inside a small scoreboard class.
// Depends on fpl_pkg and the channel interfaces in fpl_if.
module tb_top;

    localparam int FRAC         = 16;
    localparam int ITEM_CYCLES  = 32;
    localparam int ITEM_TARGET  = 1400;
    localparam int LONG_HOLD    = 400;
    localparam int TIMEOUT_NS   = 2_500_000;

    localparam logic [fpl_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = fpl_pkg::REG_DECAY + 1'b1;
    localparam logic [fpl_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;
    localparam logic [1:0]            MODE_SPARE   = 2'd3;
    localparam logic [18:0]           FB_MAX       = 19'd327679;
    localparam logic signed [17:0]    DECAY_MIN    = -18'sd131072;
    localparam logic signed [17:0]    DECAY_MAX    = 18'sd131071;
    localparam logic signed [17:0]    DECAY_ONE    = 18'sd65536;
    localparam logic signed [19:0]    TAP_03       = 20'sd19661;

    typedef logic signed [fpl_pkg::STATE_W-1:0] level_t;
    typedef logic signed [79:0]                 wide_t;

    typedef struct packed {
        logic signed [fpl_pkg::SAMPLE_W-1:0] sample;
        logic                                clipped;
    } filt_result_t;

    typedef enum {WAVE_NOISE, WAVE_QUIET, WAVE_SQUARE, WAVE_IMPULSE, WAVE_RAILS} wave_t;

    localparam wide_t LEVEL_MAX  = (80'sd1 <<< (fpl_pkg::STATE_W - 1)) - 80'sd1;
    localparam wide_t LEVEL_MIN  = -(80'sd1 <<< (fpl_pkg::STATE_W - 1));
    localparam wide_t SAMPLE_MAX = 80'sd32767;
    localparam wide_t SAMPLE_MIN = -80'sd32768;

    class ladder_scoreboard_t;
        fpl_pkg::cfg_t regs;
        level_t        pole_out [fpl_pkg::POLES];
        level_t        pole_in  [fpl_pkg::POLES];
        filt_result_t  awaited_outputs[$];
        int            errors;

        function new();
            regs = '0;
            regs.pole_decay = DECAY_ONE;
            errors = 0;
            foreach (pole_out[k])
            begin
                pole_out[k] = '0;
                pole_in[k]  = '0;
            end
        endfunction

        function int pending();
            return awaited_outputs.size();
        endfunction

        function level_t clamp48(wide_t v);
            if (v > LEVEL_MAX)
                return LEVEL_MAX[fpl_pkg::STATE_W-1:0];
            if (v < LEVEL_MIN)
                return LEVEL_MIN[fpl_pkg::STATE_W-1:0];
            return v[fpl_pkg::STATE_W-1:0];
        endfunction

        // floor(a * c / 2^16), saturated
        function level_t scale(level_t a, logic signed [19:0] c);
            wide_t p;
            p = a;
            p = p * c;
            return clamp48(p >>> 16);
        endfunction

        function void apply_reg(logic [fpl_pkg::CFG_IDX_W-1:0] idx,
                                logic [fpl_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                fpl_pkg::REG_ENABLE:   regs.enable        = data[0];
                fpl_pkg::REG_MODE:     regs.mode          = data[1:0];
                fpl_pkg::REG_FEEDBACK: regs.feedback_gain = data;
                fpl_pkg::REG_IN_GAIN:  regs.input_gain    = data[15:0];
                fpl_pkg::REG_DECAY:    regs.pole_decay    = data[17:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [fpl_pkg::SAMPLE_W-1:0] x);
            filt_result_t      r;
            wide_t             acc;
            level_t            u, s, y, v;
            logic signed [19:0] fb, ig;
            if (!regs.enable)
            begin
                r.sample  = x;
                r.clipped = 1'b0;
            end
            else
            begin
                fb  = $signed({1'b0, regs.feedback_gain});
                ig  = $signed({4'b0000, regs.input_gain});
                acc = x;
                acc = acc <<< FRAC;
                acc = acc - scale(pole_out[fpl_pkg::POLES-1], fb);
                u   = scale(clamp48(acc), ig);
                s   = u;
                for (int k = 0; k < fpl_pkg::POLES; k++)
                begin
                    acc = s;
                    acc = acc + scale(pole_in[k], TAP_03)
                              + scale(pole_out[k], regs.pole_decay);
                    y   = clamp48(acc);
                    pole_in[k]  = s;
                    pole_out[k] = y;
                    s = y;
                end
                case (regs.mode)
                    fpl_pkg::MODE_BANDPASS:
                    begin
                        acc = pole_out[fpl_pkg::POLES-2];
                        acc = (acc - pole_out[fpl_pkg::POLES-1]) * 3;
                        v   = clamp48(acc);
                    end
                    fpl_pkg::MODE_HIGHPASS:
                    begin
                        acc = u;
                        v   = clamp48(acc - pole_out[fpl_pkg::POLES-1]);
                    end
                    default: v = pole_out[fpl_pkg::POLES-1];
                endcase
                acc = v;
                acc = (acc + (80'sd1 <<< (FRAC - 1))) >>> FRAC;
                r.clipped = 1'b1;
                if (acc > SAMPLE_MAX)
                    r.sample = SAMPLE_MAX[fpl_pkg::SAMPLE_W-1:0];
                else if (acc < SAMPLE_MIN)
                    r.sample = SAMPLE_MIN[fpl_pkg::SAMPLE_W-1:0];
                else
                begin
                    r.sample  = acc[fpl_pkg::SAMPLE_W-1:0];
                    r.clipped = 1'b0;
                end
            end
            awaited_outputs.push_back(r);
        endfunction

        function void check_result(filt_result_t got);
            filt_result_t want;
            if (awaited_outputs.size() == 0)
            begin
                $error("result with no item outstanding: sample_out %0d", got.sample);
                errors++;
                return;
            end
            want = awaited_outputs.pop_front();
            if (got.sample !== want.sample)
            begin
                $error("sample_out mismatch: expected %0d, got %0d", want.sample, got.sample);
                errors++;
            end
            if (got.clipped !== want.clipped)
            begin
                $error("clipped mismatch: expected %0b, got %0b", want.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [fpl_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [fpl_pkg::CFG_DATA_W-1:0]  cfg_data;
    bit                              calm;
    int                              hold_request;
    int                              items_sent;

    ladder_scoreboard_t board = new();

    fpl_in_if  sample_ch();
    fpl_out_if result_ch();

    four_pole_ladder_filter #(.STATE_FRACTION_BITS(FRAC)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch.sink),
        .results   (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // mostly back to back, a few short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic signed [fpl_pkg::SAMPLE_W-1:0] wave_sample(wave_t style,
                                                                       int n, int amp,
                                                                       int period);
        int v;
        case (style)
            WAVE_QUIET:   v = int'($urandom_range(0, 2 * amp)) - amp;
            WAVE_SQUARE:  v = ((n / period) % 2 == 0) ? amp : -amp;
            WAVE_IMPULSE: v = (n % period == 0) ? amp : 0;
            WAVE_RAILS:   v = $urandom_range(0, 1) ? 32767 : -32768;
            default:      v = $urandom;
        endcase
        return v[fpl_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic fpl_pkg::cfg_t random_config();
        fpl_pkg::cfg_t c;
        int            k;
        k = $urandom_range(0, 99);
        c.enable = ($urandom_range(0, 9) != 0);
        c.mode   = 2'($urandom_range(0, 3));
        if (k < 60)
        begin
            // musically sensible: stable poles, moderate resonance
            c.feedback_gain = 19'($urandom_range(0, 262144));
            c.input_gain    = 16'($urandom_range(1000, 40000));
            c.pole_decay    = 18'($urandom_range(30000, 65000));
        end
        else if (k < 85)
        begin
            c.feedback_gain = 19'($urandom_range(0, FB_MAX));
            c.input_gain    = 16'($urandom);
            c.pole_decay    = 18'($urandom);
        end
        else
        begin
            c.feedback_gain = $urandom_range(0, 1) ? FB_MAX : '0;
            c.input_gain    = $urandom_range(0, 1) ? '1 : '0;
            case ($urandom_range(0, 3))
                0:       c.pole_decay = DECAY_MIN;
                1:       c.pole_decay = DECAY_MAX;
                2:       c.pole_decay = '0;
                default: c.pole_decay = DECAY_ONE;
            endcase
        end
        return c;
    endfunction

    task automatic put_reg(input logic [fpl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpl_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.apply_reg(idx, data);
    endtask

    // noisy: junk in the unused upper bits plus a write to an unmapped index
    task automatic set_registers(input fpl_pkg::cfg_t c, input bit noisy);
        logic [fpl_pkg::CFG_DATA_W-1:0] junk;
        junk = noisy ? fpl_pkg::CFG_DATA_W'($urandom) : '0;
        put_reg(fpl_pkg::REG_ENABLE,   {junk[18:1], c.enable});
        put_reg(fpl_pkg::REG_MODE,     {junk[18:2], c.mode});
        put_reg(fpl_pkg::REG_FEEDBACK, c.feedback_gain);
        put_reg(fpl_pkg::REG_IN_GAIN,  {junk[18:16], c.input_gain});
        put_reg(fpl_pkg::REG_DECAY,    {junk[18], c.pole_decay});
        if (noisy)
            put_reg(fpl_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), ~junk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic signed [fpl_pkg::SAMPLE_W-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.sample_in <= x;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        board.note_sample(x);
        items_sent++;
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        fpl_pkg::cfg_t c;
        wave_t         style;
        int            phase, count, amp, period;
        sample_ch.valid     = 1'b0;
        sample_ch.sample_in = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        calm         = 1'b1;
        hold_request = 0;
        items_sent   = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // straight through after reset
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample('0);
        drain();

        // full-scale steps into integrating poles: saturation
        c.enable        = 1'b1;
        c.mode          = fpl_pkg::MODE_LOWPASS;
        c.feedback_gain = '0;
        c.input_gain    = '1;
        c.pole_decay    = DECAY_ONE;
        set_registers(c, 1'b0);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd1);
        drain();

        c.mode          = fpl_pkg::MODE_BANDPASS;
        c.feedback_gain = FB_MAX;
        c.pole_decay    = 18'sd32768;
        set_registers(c, 1'b0);
        send_sample(16'sd12000);
        send_sample(-16'sd12000);
        send_sample(16'sd1);
        drain();

        c.mode          = fpl_pkg::MODE_HIGHPASS;
        c.feedback_gain = '0;
        c.input_gain    = 16'h8000;
        c.pole_decay    = DECAY_MIN;
        set_registers(c, 1'b0);
        send_sample(16'sd32767);
        send_sample('0);
        send_sample(-16'sd32768);
        drain();

        // unused mode code falls back to lowpass
        c.mode          = MODE_SPARE;
        c.input_gain    = '0;
        c.pole_decay    = DECAY_MAX;
        set_registers(c, 1'b0);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample('0);
        drain();

        // bypass must leave the pole state alone
        c.enable = 1'b0;
        set_registers(c, 1'b1);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        drain();

        c.enable        = 1'b1;
        c.mode          = fpl_pkg::MODE_LOWPASS;
        c.feedback_gain = 19'd65536;
        c.input_gain    = 16'd20000;
        c.pole_decay    = 18'sd60000;
        set_registers(c, 1'b0);
        send_sample(16'sd5000);
        send_sample(-16'sd5000);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            drain();
            c = random_config();
            set_registers(c, $urandom_range(0, 3) == 0);
            calm = ($urandom_range(0, 3) == 0);
            if (phase == 3)
            begin
                // output side holds off; the input should back up behind it
                calm = 1'b1;
                hold_request = LONG_HOLD;
            end
            style  = wave_t'($urandom_range(WAVE_NOISE, WAVE_RAILS));
            amp    = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(1, 8000);
            period = $urandom_range(1, 40);
            count  = $urandom_range(20, 80);
            for (int n = 0; n < count; n++)
                send_sample(wave_sample(style, n, amp, period));
            phase++;
        end

        drain();
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin : result_sink
        int           wait_left;
        filt_result_t got;
        wait_left       = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.sample  = result_ch.sample_out;
                got.clipped = result_ch.clipped;
                board.check_result(got);
            end
            if (hold_request > 0)
            begin
                wait_left    = hold_request;
                hold_request = 0;
            end
            if (wait_left > 0)
            begin
                result_ch.ready <= 1'b0;
                wait_left--;
            end
            else
            begin
                wait_left = pick_gap();
                result_ch.ready <= (wait_left == 0);
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
